/* sv/wireframe_sphere_point_generator_unit_defines.svh */
// ----------------------------------------------------------------------------
// wireframe sphere point generator assertion macros
// concurrent check helpers used by the generator unit, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef WIREFRAME_SPHERE_POINT_GENERATOR_UNIT_DEFINES_SVH
`define WIREFRAME_SPHERE_POINT_GENERATOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// check sampled on clk, ignored while reset is asserted
`define SPG_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check sampled on clk, also active during reset
`define SPG_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define SPG_ASSERT(label, prop, msg)
`define SPG_ASSERT_ALWAYS(label, prop, msg)

`endif

`endif

/* sv/wsp_pkg.sv */
// ----------------------------------------------------------------------------
// wsp_pkg
// shared types and constants of the sphere point generator
// ----------------------------------------------------------------------------
`default_nettype none

package wsp_pkg;

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_BAND,
        ST_SPLIT,
        ST_DIV,
        ST_TRIG,
        ST_COORD,
        ST_OUT
    } state_t;

    typedef enum logic [2:0]
    {
        CFG_LON_BANDS  = 3'd0,
        CFG_LAT_BANDS  = 3'd1,
        CFG_RADIUS     = 3'd2,
        CFG_STEP_X     = 3'd3,
        CFG_STEP_Y     = 3'd4,
        CFG_STEP_Z     = 3'd5,
        CFG_THRESHOLD  = 3'd6
    } cfg_idx_t;

    localparam int CFG_IDX_BITS  = 3;
    localparam int CFG_DATA_BITS = 16;

    // shared multiplier operand and product widths
    localparam int MUL_A_BITS = 35;
    localparam int MUL_B_BITS = 26;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

    // quarter-wave sine polynomial, unsigned q24
    localparam logic [25:0] Q24_ONE = 26'd16777216;
    localparam logic [25:0] SIN_C1  = 26'd26353589;
    localparam logic [25:0] SIN_C3  = 26'd10837479;
    localparam logic [25:0] SIN_C5  = 26'd1337020;
    localparam logic [25:0] SIN_C7  = 26'd78547;
    localparam logic [25:0] SIN_C9  = 26'd2692;

endpackage

`default_nettype wire

/* sv/wsp_in_if.sv */
// ----------------------------------------------------------------------------
// wsp_in_if
// phase channel: valid/ready handshake with one sweep phase per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface wsp_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] phase;

    modport source (output valid, output phase, input ready);
    modport sink   (input valid, input phase, output ready);
endinterface

`default_nettype wire

/* sv/wsp_out_if.sv */
// ----------------------------------------------------------------------------
// wsp_out_if
// point channel: valid/ready handshake with one x, y, z point per beat
// ----------------------------------------------------------------------------
`default_nettype none

interface wsp_out_if #(parameter int COORD_BITS = 16);
    logic                         valid;
    logic                         ready;
    logic signed [COORD_BITS-1:0] point_x;
    logic signed [COORD_BITS-1:0] point_y;
    logic signed [COORD_BITS-1:0] point_z;

    modport source (output valid, output point_x, output point_y, output point_z,
                    input ready);
    modport sink   (input valid, input point_x, input point_y, input point_z,
                    output ready);
endinterface

`default_nettype wire

/* sv/wsp_div.sv */
// ----------------------------------------------------------------------------
// wsp_div
// bit-serial restoring divider, one quotient bit per cycle, 8-bit divisor
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_div #(
    parameter int NW = 24
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [7:0]    divisor,
    output logic               busy,
    output logic [NW-1:0]      quotient
);

    localparam int CNT_BITS = $clog2(NW + 1);

    logic [CNT_BITS-1:0] cnt_reg;
    logic [NW-1:0]       quo_reg;
    logic [7:0]          rem_reg;
    logic [8:0]          rem_sh;
    logic                fits;

    assign rem_sh = {rem_reg, quo_reg[NW-1]};
    assign fits   = (rem_sh >= {1'b0, divisor});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else if (start)
        begin
            cnt_reg <= CNT_BITS'(NW);
        end
        else if (cnt_reg != '0)
        begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (cnt_reg != '0)
        begin
            // shift in next dividend bit, subtract when it fits
            rem_reg <= fits ? 8'(rem_sh - {1'b0, divisor}) : rem_sh[7:0];
            quo_reg <= {quo_reg[NW-2:0], fits};
        end
    end

    assign busy     = (cnt_reg != '0);
    assign quotient = quo_reg;

endmodule

`default_nettype wire

/* sv/wsp_mul.sv */
// ----------------------------------------------------------------------------
// wsp_mul
// shared signed multiplier with registered product
// ----------------------------------------------------------------------------
`default_nettype none

module wsp_mul (
    input  wire logic                                  clk,
    input  wire logic signed [wsp_pkg::MUL_A_BITS-1:0] a,
    input  wire logic signed [wsp_pkg::MUL_B_BITS-1:0] b,
    output logic signed [wsp_pkg::MUL_P_BITS-1:0]      p
);

    logic signed [wsp_pkg::MUL_P_BITS-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= wsp_pkg::MUL_P_BITS'(a) * wsp_pkg::MUL_P_BITS'(b);
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* sv/wireframe_sphere_point_generator_unit.sv */
// ----------------------------------------------------------------------------
// wireframe_sphere_point_generator_unit
// sweep phase to rotated point on a wireframe sphere, one shared multiplier
// ----------------------------------------------------------------------------
// Each phase beat gives one point beat. The phase is cut into meridian bands
// then parallel bands; band index and in-band position give the spherical
// angles, the point on the sphere of the configured radius is rotated about
// x, y then z by three tilt registers, and the rounded, saturated x, y, z are
// sent out. A phase strictly above the tilt threshold register advances the
// tilts by their steps after the point is formed. A point is formed by
// taking the phase, the band product, the band split, a serial band
// divide that holds the sequencer, ten sine evaluations, eighteen
// coordinate steps and the output beat, in that order; the band product,
// the sine evaluations and the coordinate steps all run through the
// single registered multiplier. With no bands configured at all the
// divide is skipped. The phase channel is ready only while the unit is
// idle, and the finished point is held until it is taken, so a new phase
// is taken only after the last point has gone.
`default_nettype none

`include "wireframe_sphere_point_generator_unit_defines.svh"

module wireframe_sphere_point_generator_unit #(
    parameter int ANGLE_BITS = 16,
    parameter int COORD_BITS = 16
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_we,
    input  wire logic [wsp_pkg::CFG_IDX_BITS-1:0]     cfg_index,
    input  wire logic [wsp_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    wsp_in_if.sink                                    phase_ch,
    wsp_out_if.source                                 point_ch
);

    localparam int A  = ANGLE_BITS;
    localparam int NW = 8 + A;                  // divider dividend width
    localparam int CW = 35;                     // q16 coordinate width
    localparam int PW = wsp_pkg::MUL_P_BITS;
    localparam int TB = 18;                     // q16 trig value width

    // trig slots: sin/cos of theta, phi and the three tilts
    localparam logic [3:0] T_ST = 4'd0;
    localparam logic [3:0] T_CT = 4'd1;
    localparam logic [3:0] T_SP = 4'd2;
    localparam logic [3:0] T_CP = 4'd3;
    localparam logic [3:0] T_SX = 4'd4;
    localparam logic [3:0] T_CX = 4'd5;
    localparam logic [3:0] T_SY = 4'd6;
    localparam logic [3:0] T_CY = 4'd7;
    localparam logic [3:0] T_SZ = 4'd8;
    localparam logic [3:0] T_CZ = 4'd9;
    localparam logic [2:0] K_LAST = 3'd6;
    localparam logic [4:0] C_LAST = 5'd17;

    localparam logic [A-1:0] QUARTER = A'(1) << (A - 2);
    localparam logic signed [CW-1:0] OUT_LIM = CW'((64'sd1 <<< (COORD_BITS - 1)) - 1);
    localparam logic [24:0] Q24_ONE_25 = wsp_pkg::Q24_ONE[24:0];

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [7:0]  lon_reg;
    logic [7:0]  lat_reg;
    logic [14:0] radius_reg;
    logic [15:0] step_x_reg;
    logic [15:0] step_y_reg;
    logic [15:0] step_z_reg;
    logic [15:0] thr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lon_reg    <= 8'd8;
            lat_reg    <= 8'd8;
            radius_reg <= 15'd32767;
            step_x_reg <= '0;
            step_y_reg <= '0;
            step_z_reg <= '0;
            thr_reg    <= 16'hFFFF;
        end
        else if (cfg_we)
        begin
            unique case (wsp_pkg::cfg_idx_t'(cfg_index))
                wsp_pkg::CFG_LON_BANDS: lon_reg    <= cfg_data[7:0];
                wsp_pkg::CFG_LAT_BANDS: lat_reg    <= cfg_data[7:0];
                wsp_pkg::CFG_RADIUS:    radius_reg <= cfg_data[14:0];
                wsp_pkg::CFG_STEP_X:    step_x_reg <= cfg_data;
                wsp_pkg::CFG_STEP_Y:    step_y_reg <= cfg_data;
                wsp_pkg::CFG_STEP_Z:    step_z_reg <= cfg_data;
                wsp_pkg::CFG_THRESHOLD: thr_reg    <= cfg_data;
                default:                ;   // unused index, write dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // sequencer and datapath state
    // ------------------------------------------------------------------
    wsp_pkg::state_t state_reg, state_next;

    logic [15:0]   tilt_x_reg, tilt_y_reg, tilt_z_reg;
    logic [15:0]   phase_reg;
    logic          meridian_reg;
    logic [A-1:0]  theta_reg, phi_reg;
    logic [3:0]    ti_reg;                      // trig slot in progress
    logic [2:0]    k_reg;                       // step inside one sine
    logic [4:0]    c_reg;                       // coordinate step
    logic [24:0]   xin_reg, x2_reg;
    logic [1:0]    q_reg;
    logic signed [TB-1:0] trig_reg [10];
    logic signed [CW-1:0] x_reg, y_reg, z_reg, t1_reg;
    logic signed [CW-1:0] yx_reg, zx_reg, xy_reg, zy_reg, xz_reg;
    logic signed [COORD_BITS-1:0] px_reg, py_reg, pz_reg;

    // shared multiplier
    logic signed [wsp_pkg::MUL_A_BITS-1:0] mul_a;
    logic signed [wsp_pkg::MUL_B_BITS-1:0] mul_b;
    logic signed [PW-1:0]                  prod;

    wsp_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (prod)
    );

    // band divider
    logic          div_start;
    logic [NW-1:0] div_dividend;
    logic          div_busy;
    logic [NW-1:0] div_quo;

    wsp_div #(.NW(NW)) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (meridian_reg ? lon_reg : lat_reg),
        .busy     (div_busy),
        .quotient (div_quo)
    );

    // ------------------------------------------------------------------
    // helpers
    // ------------------------------------------------------------------

    // product / 65536, rounded half away from zero
    function automatic logic signed [CW-1:0] rnd_prod(input logic signed [PW-1:0] p);
        logic [PW-1:0] mag;
        logic [PW-1:0] m;
        begin
            mag = p[PW-1] ? PW'(-p) : PW'(p);
            m   = (mag + PW'(32768)) >> 16;
            rnd_prod = p[PW-1] ? -$signed(CW'(m)) : $signed(CW'(m));
        end
    endfunction

    // q16 coordinate to rounded, saturated output
    function automatic logic signed [COORD_BITS-1:0] to_out(input logic signed [CW-1:0] v);
        logic [CW-1:0]        mag;
        logic [CW-1:0]        m;
        logic signed [CW-1:0] r;
        begin
            mag = v[CW-1] ? CW'(-v) : CW'(v);
            m   = (mag + CW'(32768)) >> 16;
            r   = v[CW-1] ? -$signed(m) : $signed(m);
            if (r > OUT_LIM)
            begin
                r = OUT_LIM;
            end
            else if (r < -OUT_LIM)
            begin
                r = -OUT_LIM;
            end
            to_out = COORD_BITS'(r);
        end
    endfunction

    // 16-bit turn fraction scaled to the angle width
    function automatic logic [A-1:0] tilt_angle(input logic [15:0] t);
        logic [A+15:0] w;
        begin
            w = {t, {A{1'b0}}};
            tilt_angle = w[A+15:16];
        end
    endfunction

    // ------------------------------------------------------------------
    // band split
    // ------------------------------------------------------------------
    logic [8:0]    band;
    logic [15:0]   inner;
    logic          is_meridian;
    logic [7:0]    lat_band;
    logic [A+15:0] inner_full;
    logic [A+14:0] inner_half;

    assign band        = prod[24:16];
    assign inner       = prod[15:0];
    assign is_meridian = (band < {1'b0, lon_reg});
    assign lat_band    = 8'(band - {1'b0, lon_reg});
    assign inner_full  = {inner, {A{1'b0}}};
    assign inner_half  = {inner, {(A-1){1'b0}}};

    // ------------------------------------------------------------------
    // sine argument reduction
    // ------------------------------------------------------------------
    logic [A-1:0] ang;
    logic [1:0]   ang_q;
    logic [23:0]  ang_x;
    logic [24:0]  sin_x;
    logic [25:0]  hp;
    logic [24:0]  sin_clamp;
    logic [16:0]  sin_round;

    always_comb
    begin
        case (ti_reg)
            T_ST:    ang = theta_reg;
            T_CT:    ang = theta_reg + QUARTER;
            T_SP:    ang = phi_reg;
            T_CP:    ang = phi_reg + QUARTER;
            T_SX:    ang = tilt_angle(tilt_x_reg);
            T_CX:    ang = tilt_angle(tilt_x_reg) + QUARTER;
            T_SY:    ang = tilt_angle(tilt_y_reg);
            T_CY:    ang = tilt_angle(tilt_y_reg) + QUARTER;
            T_SZ:    ang = tilt_angle(tilt_z_reg);
            default: ang = tilt_angle(tilt_z_reg) + QUARTER;
        endcase
    end

    assign ang_q     = ang[A-1:A-2];
    assign ang_x     = {ang[A-3:0], {(26-A){1'b0}}};
    assign sin_x     = ang_q[0] ? 25'(Q24_ONE_25 - {1'b0, ang_x}) : {1'b0, ang_x};
    assign hp        = prod[49:24];
    assign sin_clamp = (hp > wsp_pkg::Q24_ONE) ? wsp_pkg::Q24_ONE[24:0] : hp[24:0];
    assign sin_round = 17'((sin_clamp + 25'd128) >> 8);

    logic signed [CW-1:0] rp;
    assign rp = rnd_prod(prod);

    // ------------------------------------------------------------------
    // multiplier operand selection
    // ------------------------------------------------------------------
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            wsp_pkg::ST_BAND:
            begin
                mul_a = wsp_pkg::MUL_A_BITS'(phase_reg);
                mul_b = wsp_pkg::MUL_B_BITS'({1'b0, lon_reg} + {1'b0, lat_reg});
            end
            wsp_pkg::ST_TRIG:
            begin
                case (k_reg)
                    3'd0:
                    begin
                        mul_a = wsp_pkg::MUL_A_BITS'(sin_x);
                        mul_b = wsp_pkg::MUL_B_BITS'(sin_x);
                    end
                    3'd1:
                    begin
                        mul_a = wsp_pkg::MUL_A_BITS'(prod[48:24]);
                        mul_b = wsp_pkg::SIN_C9;
                    end
                    3'd2:
                    begin
                        mul_a = wsp_pkg::MUL_A_BITS'(x2_reg);
                        mul_b = wsp_pkg::SIN_C7 - hp;
                    end
                    3'd3:
                    begin
                        mul_a = wsp_pkg::MUL_A_BITS'(x2_reg);
                        mul_b = wsp_pkg::SIN_C5 - hp;
                    end
                    3'd4:
                    begin
                        mul_a = wsp_pkg::MUL_A_BITS'(x2_reg);
                        mul_b = wsp_pkg::SIN_C3 - hp;
                    end
                    3'd5:
                    begin
                        mul_a = wsp_pkg::MUL_A_BITS'(xin_reg);
                        mul_b = wsp_pkg::SIN_C1 - hp;
                    end
                    default: ;
                endcase
            end
            wsp_pkg::ST_COORD:
            begin
                case (c_reg)
                    5'd0:  begin mul_a = CW'(radius_reg);     mul_b = 26'(trig_reg[T_CT]); end
                    5'd1:  begin mul_a = prod[CW-1:0];        mul_b = 26'(trig_reg[T_SP]); end
                    5'd2:  begin mul_a = CW'(radius_reg);     mul_b = 26'(trig_reg[T_ST]); end
                    5'd3:  begin mul_a = prod[CW-1:0];        mul_b = 26'(trig_reg[T_SP]); end
                    5'd4:  begin mul_a = CW'(radius_reg);     mul_b = 26'(trig_reg[T_CP]); end
                    5'd5:  begin mul_a = y_reg;               mul_b = 26'(trig_reg[T_CX]); end
                    5'd6:  begin mul_a = z_reg;               mul_b = 26'(trig_reg[T_SX]); end
                    5'd7:  begin mul_a = y_reg;               mul_b = 26'(trig_reg[T_SX]); end
                    5'd8:  begin mul_a = z_reg;               mul_b = 26'(trig_reg[T_CX]); end
                    5'd9:  begin mul_a = x_reg;               mul_b = 26'(trig_reg[T_CY]); end
                    5'd10: begin mul_a = zx_reg;              mul_b = 26'(trig_reg[T_SY]); end
                    5'd11: begin mul_a = zx_reg;              mul_b = 26'(trig_reg[T_CY]); end
                    5'd12: begin mul_a = x_reg;               mul_b = 26'(trig_reg[T_SY]); end
                    5'd13: begin mul_a = xy_reg;              mul_b = 26'(trig_reg[T_CZ]); end
                    5'd14: begin mul_a = yx_reg;              mul_b = 26'(trig_reg[T_SZ]); end
                    5'd15: begin mul_a = xy_reg;              mul_b = 26'(trig_reg[T_SZ]); end
                    5'd16: begin mul_a = yx_reg;              mul_b = 26'(trig_reg[T_CZ]); end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next   = state_reg;
        div_start    = 1'b0;
        div_dividend = is_meridian ? {band[7:0], {A{1'b0}}}
                                   : {1'b0, lat_band, {(A-1){1'b0}}};
        unique case (state_reg)
            wsp_pkg::ST_IDLE:
            begin
                if (phase_ch.valid)
                begin
                    state_next = wsp_pkg::ST_BAND;
                end
            end
            wsp_pkg::ST_BAND:
            begin
                state_next = wsp_pkg::ST_SPLIT;
            end
            wsp_pkg::ST_SPLIT:
            begin
                // no parallel bands configured: phi stays at the pole
                if (!is_meridian && (lat_reg == '0))
                begin
                    state_next = wsp_pkg::ST_TRIG;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = wsp_pkg::ST_DIV;
                end
            end
            wsp_pkg::ST_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = wsp_pkg::ST_TRIG;
                end
            end
            wsp_pkg::ST_TRIG:
            begin
                if ((k_reg == K_LAST) && (ti_reg == T_CZ))
                begin
                    state_next = wsp_pkg::ST_COORD;
                end
            end
            wsp_pkg::ST_COORD:
            begin
                if (c_reg == C_LAST)
                begin
                    state_next = wsp_pkg::ST_OUT;
                end
            end
            wsp_pkg::ST_OUT:
            begin
                if (point_ch.ready)
                begin
                    state_next = wsp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = wsp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= wsp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // ------------------------------------------------------------------
    // control counters and tilts
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ti_reg     <= '0;
            k_reg      <= '0;
            c_reg      <= '0;
            tilt_x_reg <= '0;
            tilt_y_reg <= '0;
            tilt_z_reg <= '0;
        end
        else
        begin
            case (state_reg)
                wsp_pkg::ST_SPLIT,
                wsp_pkg::ST_DIV:
                begin
                    ti_reg <= '0;
                    k_reg  <= '0;
                    c_reg  <= '0;
                end
                wsp_pkg::ST_TRIG:
                begin
                    if (k_reg == K_LAST)
                    begin
                        k_reg  <= '0;
                        ti_reg <= ti_reg + 1'b1;
                    end
                    else
                    begin
                        k_reg <= k_reg + 1'b1;
                    end
                end
                wsp_pkg::ST_COORD:
                begin
                    c_reg <= c_reg + 1'b1;
                    // tilts advance after the point used the old ones
                    if ((c_reg == C_LAST) && (phase_reg > thr_reg))
                    begin
                        tilt_x_reg <= tilt_x_reg + step_x_reg;
                        tilt_y_reg <= tilt_y_reg + step_y_reg;
                        tilt_z_reg <= tilt_z_reg + step_z_reg;
                    end
                end
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        case (state_reg)
            wsp_pkg::ST_IDLE:
            begin
                phase_reg <= phase_ch.phase;
            end
            wsp_pkg::ST_SPLIT:
            begin
                meridian_reg <= is_meridian;
                if (is_meridian)
                begin
                    phi_reg <= A'(inner_half[A+14:16]);
                end
                else
                begin
                    theta_reg <= inner_full[A+15:16];
                    phi_reg   <= '0;
                end
            end
            wsp_pkg::ST_DIV:
            begin
                if (!div_busy)
                begin
                    if (meridian_reg)
                    begin
                        theta_reg <= div_quo[A-1:0];
                    end
                    else
                    begin
                        phi_reg <= div_quo[A-1:0];
                    end
                end
            end
            wsp_pkg::ST_TRIG:
            begin
                case (k_reg)
                    3'd0:
                    begin
                        xin_reg <= sin_x;
                        q_reg   <= ang_q;
                    end
                    3'd1:
                    begin
                        x2_reg <= prod[48:24];
                    end
                    K_LAST:
                    begin
                        trig_reg[ti_reg] <= q_reg[1] ? -$signed({1'b0, sin_round})
                                                     :  $signed({1'b0, sin_round});
                    end
                    default: ;
                endcase
            end
            wsp_pkg::ST_COORD:
            begin
                case (c_reg)
                    5'd2:  x_reg  <= rp;
                    5'd4:  y_reg  <= rp;
                    5'd5:  z_reg  <= prod[CW-1:0];
                    5'd6,
                    5'd8,
                    5'd10,
                    5'd12,
                    5'd14,
                    5'd16: t1_reg <= rp;
                    5'd7:  yx_reg <= t1_reg - rp;
                    5'd9:  zx_reg <= t1_reg + rp;
                    5'd11: xy_reg <= t1_reg + rp;
                    5'd13: zy_reg <= t1_reg - rp;
                    5'd15: xz_reg <= t1_reg - rp;
                    C_LAST:
                    begin
                        px_reg <= to_out(xz_reg);
                        py_reg <= to_out(t1_reg + rp);
                        pz_reg <= to_out(zy_reg);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // ------------------------------------------------------------------
    // channel outputs
    // ------------------------------------------------------------------
    assign phase_ch.ready   = (state_reg == wsp_pkg::ST_IDLE);
    assign point_ch.valid   = (state_reg == wsp_pkg::ST_OUT);
    assign point_ch.point_x = px_reg;
    assign point_ch.point_y = py_reg;
    assign point_ch.point_z = pz_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `SPG_ASSERT(a_no_overlap, !(phase_ch.ready && point_ch.valid),
                "phase accepted while a point is pending")
    `SPG_ASSERT(a_busy_after_beat, (phase_ch.valid && phase_ch.ready) |=> !phase_ch.ready,
                "unit ready again right after taking a phase")
    `SPG_ASSERT(a_tilt_hold, (state_reg != wsp_pkg::ST_COORD) |=> $stable(tilt_x_reg),
                "tilt moved outside the coordinate pass")
    `SPG_ASSERT_ALWAYS(a_div_idle, (state_reg == wsp_pkg::ST_IDLE) |-> !div_busy,
                "divider running while idle")

endmodule

`default_nettype wire
